// ===== hw/rtl/fdr_pkg.sv =====
// Shared types, widths and constants of the Fresnel dielectric reflectance unit.
// No dependencies; every other file of the block imports this package.
package fdr_pkg;

	localparam int IDX_W   = 16;   // refractive index, unsigned Q4.12
	localparam int COS_W   = 16;   // signed cosine, Q1.15
	localparam int C_W     = 17;   // cosine magnitude, 0 to 1.0 in Q1.15
	localparam int CC_W    = 34;   // squared cosine, Q30
	localparam int SQ_W    = 32;   // squared index
	localparam int S2_W    = 31;   // squared sine, Q30, up to 1.0
	localparam int NUM_W   = 62;   // scaled squared sine before the division
	localparam int ST2_W   = 30;   // transmitted squared sine, Q30
	localparam int RAD_W   = 31;   // square root operand
	localparam int ROOT_W  = 16;   // transmitted cosine, Q15
	localparam int PROD_W  = 33;   // index times cosine, Q27
	localparam int RSUM_W  = 34;   // sum of two products
	localparam int RNUM_W  = 49;   // ratio dividend
	localparam int RQ_W    = 16;   // amplitude ratio, Q15
	localparam int REFL_W  = 16;   // reflectance, Q1.15

	localparam int CFG_ADDR_W = 2;

	localparam logic [CFG_ADDR_W-1:0] REG_INDEX_OUTSIDE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_INDEX_INSIDE  = 2'd1;

	localparam logic [IDX_W-1:0]  INDEX_OUTSIDE_RST = 16'd4096;
	localparam logic [IDX_W-1:0]  INDEX_INSIDE_RST  = 16'd6144;
	localparam logic [CC_W-1:0]   ONE_Q30_CC        = 34'd1 << 30;
	localparam logic [RAD_W-1:0]  ONE_Q30_RAD       = 31'd1 << 30;
	localparam logic [RQ_W-1:0]   ONE_Q15           = 16'd32768;
	localparam logic [REFL_W-1:0] ONE_REFL          = 16'd32768;

	// Item data that rides alongside the long arithmetic units.
	typedef struct packed {
		logic             tir;
		logic [C_W-1:0]   c;
		logic [IDX_W-1:0] ni;
		logic [IDX_W-1:0] nt;
	} side_t;

endpackage

// ===== hw/rtl/fdr_st2_div.sv =====
// Pipelined restoring divider for the transmitted squared sine, one quotient bit per stage.
// Depends on fdr_pkg.
module fdr_st2_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ce,
	input  logic                      in_valid,
	input  logic [fdr_pkg::NUM_W-1:0] num,
	input  logic [fdr_pkg::SQ_W-1:0]  den,
	input  fdr_pkg::side_t            side_in,
	output logic                      out_valid,
	output logic [fdr_pkg::ST2_W-1:0] quot,
	output fdr_pkg::side_t            side_out
);
	import fdr_pkg::*;

	logic [NUM_W-1:0] rem_s  [ST2_W+1];
	logic [SQ_W-1:0]  den_s  [ST2_W+1];
	logic [ST2_W-1:0] quo_s  [ST2_W+1];
	side_t            side_s [ST2_W+1];
	logic             vld_s  [ST2_W+1];

	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_valid;

	for (genvar i = 0; i < ST2_W; i++) begin : g_stage
		localparam int SH = ST2_W - 1 - i;
		logic [NUM_W+1:0] trial;
		logic             ge;

		always_comb begin
			trial = {2'b00, rem_s[i]} - ({{(NUM_W + 2 - SQ_W){1'b0}}, den_s[i]} << SH);
			ge    = ~trial[NUM_W+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (ce) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[i+1]  <= ge ? trial[NUM_W-1:0] : rem_s[i];
				den_s[i+1]  <= den_s[i];
				quo_s[i+1]  <= {quo_s[i][ST2_W-2:0], ge};
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[ST2_W];
	assign quot      = quo_s[ST2_W];
	assign side_out  = side_s[ST2_W];

endmodule

// ===== hw/rtl/fdr_sqrt.sv =====
// Pipelined integer square root, floor result, one root bit per stage.
// Depends on fdr_pkg.
module fdr_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ce,
	input  logic                       in_valid,
	input  logic [fdr_pkg::RAD_W-1:0]  rad,
	input  fdr_pkg::side_t             side_in,
	output logic                       out_valid,
	output logic [fdr_pkg::ROOT_W-1:0] root,
	output fdr_pkg::side_t             side_out
);
	import fdr_pkg::*;

	localparam int W = 32;

	logic [W-1:0]    v_s    [ROOT_W+1];
	logic [W-1:0]    r_s    [ROOT_W+1];
	side_t           side_s [ROOT_W+1];
	logic            vld_s  [ROOT_W+1];

	assign v_s[0]    = {{(W - RAD_W){1'b0}}, rad};
	assign r_s[0]    = '0;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_valid;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		localparam logic [W-1:0] BIT = 32'd1 << (2 * (ROOT_W - 1 - i));
		logic [W-1:0] tgt;
		logic         ge;

		always_comb begin
			tgt = r_s[i] + BIT;
			ge  = v_s[i] >= tgt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (ce) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				v_s[i+1]    <= ge ? v_s[i] - tgt : v_s[i];
				r_s[i+1]    <= ge ? (r_s[i] >> 1) + BIT : r_s[i] >> 1;
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[ROOT_W];
	assign root      = r_s[ROOT_W][ROOT_W-1:0];
	assign side_out  = side_s[ROOT_W];

endmodule

// ===== hw/rtl/fdr_ratio.sv =====
// Amplitude ratio |x - y| / (x + y) in Q15, rounded half up, as a pipelined divider.
// Depends on fdr_pkg.
module fdr_ratio (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ce,
	input  logic                       in_valid,
	input  logic [fdr_pkg::PROD_W-1:0] x,
	input  logic [fdr_pkg::PROD_W-1:0] y,
	input  logic                       tir_in,
	output logic                       out_valid,
	output logic [fdr_pkg::RQ_W-1:0]   ratio,
	output logic                       tir_out
);
	import fdr_pkg::*;

	logic [PROD_W-1:0] diff;
	logic [RSUM_W-1:0] sum;

	logic [RNUM_W-1:0] rem_s  [RQ_W+1];
	logic [RSUM_W-1:0] den_s  [RQ_W+1];
	logic [RQ_W-1:0]   quo_s  [RQ_W+1];
	logic              zero_s [RQ_W+1];
	logic              tir_s  [RQ_W+1];
	logic              vld_s  [RQ_W+1];

	always_comb begin
		diff = (x > y) ? x - y : y - x;
		sum  = {1'b0, x} + {1'b0, y};
	end

	// Entry stage: dividend d * 2^15 + s / 2 and the zero-denominator case.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (ce) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s[0]  <= {1'b0, diff, 15'b0} + {{(RNUM_W - RSUM_W + 1){1'b0}}, sum[RSUM_W-1:1]};
			den_s[0]  <= sum;
			quo_s[0]  <= '0;
			zero_s[0] <= (sum == '0);
			tir_s[0]  <= tir_in;
		end
	end

	for (genvar i = 0; i < RQ_W; i++) begin : g_stage
		localparam int SH = RQ_W - 1 - i;
		logic [RNUM_W+1:0] trial;
		logic              ge;

		always_comb begin
			trial = {2'b00, rem_s[i]} - ({{(RNUM_W + 2 - RSUM_W){1'b0}}, den_s[i]} << SH);
			ge    = ~trial[RNUM_W+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (ce) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[i+1]  <= ge ? trial[RNUM_W-1:0] : rem_s[i];
				den_s[i+1]  <= den_s[i];
				quo_s[i+1]  <= {quo_s[i][RQ_W-2:0], ge};
				zero_s[i+1] <= zero_s[i];
				tir_s[i+1]  <= tir_s[i];
			end
		end
	end

	// A zero denominator only comes from a zero cosine against a zero index: ratio is 1.0.
	assign out_valid = vld_s[RQ_W];
	assign ratio     = zero_s[RQ_W] ? ONE_Q15 : quo_s[RQ_W];
	assign tir_out   = tir_s[RQ_W];

endmodule

// ===== hw/rtl/fresnel_dielectric_reflectance_unit.sv =====
// Fresnel dielectric reflectance unit: unpolarized reflectance from the cosine of incidence.
// Depends on fdr_pkg, fdr_st2_div, fdr_sqrt and fdr_ratio.
//
// Usage. The slave stream carries one beat per ray hit: s_tdata is the signed Q1.15
// cosine of the incidence angle, positive when the ray enters the inner medium. The
// master stream returns one beat per input beat, in order: m_tdata is the reflectance
// in unsigned Q1.15 (32768 is 1.0) and m_tuser flags total internal reflection.
// The two refractive indices (unsigned Q4.12) are written over the cfg channel, index 0
// for the outer medium and index 1 for the inner one; writes to other indices are
// dropped. The cfg channel is always ready and should only be written while idle.
//
// Throughput is one beat per cycle while the receiver keeps up. An accepted input beat
// reaches the matching output beat through five front stages, a 30-stage divider for the
// transmitted squared sine, a 16-stage square root, a product stage, two 17-stage
// ratio dividers in parallel, a squaring stage and the output register.
// When the receiver stalls with a beat pending, the whole pipeline holds and s_tready
// drops; nothing is lost or repeated, and flow resumes the cycle m_tready returns.
// Reset clears every valid bit and loads the indices with 1.0 (outer) and 1.5 (inner).
module fresnel_dielectric_reflectance_unit
	import fdr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [COS_W-1:0]      s_tdata,     // [15:0] cos_incident
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [REFL_W-1:0]     m_tdata,     // [15:0] reflectance
	output logic                  m_tuser,     // [0] total_internal
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_index,
	input  logic [IDX_W-1:0]      cfg_data
);

	// Index registers.
	logic [IDX_W-1:0] index_outside_q;
	logic [IDX_W-1:0] index_inside_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_outside_q <= INDEX_OUTSIDE_RST;
			index_inside_q  <= INDEX_INSIDE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INDEX_OUTSIDE: index_outside_q <= cfg_data;
				REG_INDEX_INSIDE:  index_inside_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline advances as one whenever the output register is free or being drained.
	logic ce;
	assign ce       = ~m_tvalid | m_tready;
	assign s_tready = ce;

	// Stage 1: pick direction. A cosine that is not positive swaps the indices and is
	// negated; the most negative code becomes exactly 1.0.
	logic           entering;
	logic [C_W-1:0] c_mag;
	always_comb begin
		entering = ~s_tdata[COS_W-1] & (s_tdata != '0);
		c_mag    = entering ? {1'b0, s_tdata} : C_W'(0) - {s_tdata[COS_W-1], s_tdata};
	end

	logic vld_s1;
	side_t side_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			side_s1.tir <= 1'b0;
			side_s1.c   <= c_mag;
			side_s1.ni  <= entering ? index_outside_q : index_inside_q;
			side_s1.nt  <= entering ? index_inside_q : index_outside_q;
		end
	end

	// Stage 2: the three squares.
	logic            vld_s2;
	side_t           side_s2;
	logic [CC_W-1:0] cc_s2;
	logic [SQ_W-1:0] ni2_s2;
	logic [SQ_W-1:0] nt2_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (ce) begin
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			side_s2 <= side_s1;
			cc_s2   <= {{(CC_W - C_W){1'b0}}, side_s1.c} * {{(CC_W - C_W){1'b0}}, side_s1.c};
			ni2_s2  <= {{(SQ_W - IDX_W){1'b0}}, side_s1.ni} * {{(SQ_W - IDX_W){1'b0}}, side_s1.ni};
			nt2_s2  <= {{(SQ_W - IDX_W){1'b0}}, side_s1.nt} * {{(SQ_W - IDX_W){1'b0}}, side_s1.nt};
		end
	end

	// Stage 3: squared sine of incidence, 1 - c^2, exact in Q30.
	logic            vld_s3;
	side_t           side_s3;
	logic [S2_W-1:0] s2_s3;
	logic [SQ_W-1:0] ni2_s3;
	logic [SQ_W-1:0] nt2_s3;
	logic [CC_W-1:0] s2_full;
	assign s2_full = ONE_Q30_CC - cc_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (ce) begin
			vld_s3 <= vld_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			side_s3 <= side_s2;
			s2_s3   <= s2_full[S2_W-1:0];
			ni2_s3  <= ni2_s2;
			nt2_s3  <= nt2_s2;
		end
	end

	// Stage 4: numerator ni^2 * sin^2.
	logic             vld_s4;
	side_t            side_s4;
	logic [NUM_W-1:0] num_s4;
	logic [SQ_W-1:0]  nt2_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (ce) begin
			vld_s4 <= vld_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			side_s4 <= side_s3;
			num_s4  <= {{(NUM_W - SQ_W){1'b0}}, ni2_s3} * {{(NUM_W - S2_W){1'b0}}, s2_s3};
			nt2_s4  <= nt2_s3;
		end
	end

	// Stage 5: exact total internal reflection test, ni^2 sin^2 >= nt^2.
	// A zero transmitted index always lands here.
	logic             vld_s5;
	side_t            side_s5;
	logic [NUM_W-1:0] num_s5;
	logic [SQ_W-1:0]  nt2_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (ce) begin
			vld_s5 <= vld_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			side_s5 <= {num_s4 >= {nt2_s4, {(NUM_W - SQ_W){1'b0}}},
				side_s4.c, side_s4.ni, side_s4.nt};
			num_s5  <= num_s4;
			nt2_s5  <= nt2_s4;
		end
	end

	// Transmitted squared sine.
	logic             div_valid;
	logic [ST2_W-1:0] st2;
	side_t            div_side;

	fdr_st2_div u_st2_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (vld_s5),
		.num       (num_s5),
		.den       (nt2_s5),
		.side_in   (side_s5),
		.out_valid (div_valid),
		.quot      (st2),
		.side_out  (div_side)
	);

	// Transmitted cosine.
	logic              sqrt_valid;
	logic [ROOT_W-1:0] ct;
	side_t             sqrt_side;
	logic [RAD_W-1:0]  rad;
	assign rad = ONE_Q30_RAD - {{(RAD_W - ST2_W){1'b0}}, st2};

	fdr_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (div_valid),
		.rad       (rad),
		.side_in   (div_side),
		.out_valid (sqrt_valid),
		.root      (ct),
		.side_out  (sqrt_side)
	);

	// Stage 7: the four Q27 products of the two amplitude ratios.
	logic              vld_s7;
	logic              tir_s7;
	logic [PROD_W-1:0] xpar_s7;
	logic [PROD_W-1:0] ypar_s7;
	logic [PROD_W-1:0] xperp_s7;
	logic [PROD_W-1:0] yperp_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (ce) begin
			vld_s7 <= sqrt_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			tir_s7   <= sqrt_side.tir;
			xpar_s7  <= {{(PROD_W - IDX_W){1'b0}}, sqrt_side.nt}
				* {{(PROD_W - C_W){1'b0}}, sqrt_side.c};
			ypar_s7  <= {{(PROD_W - IDX_W){1'b0}}, sqrt_side.ni}
				* {{(PROD_W - ROOT_W){1'b0}}, ct};
			xperp_s7 <= {{(PROD_W - IDX_W){1'b0}}, sqrt_side.ni}
				* {{(PROD_W - C_W){1'b0}}, sqrt_side.c};
			yperp_s7 <= {{(PROD_W - IDX_W){1'b0}}, sqrt_side.nt}
				* {{(PROD_W - ROOT_W){1'b0}}, ct};
		end
	end

	// Parallel and perpendicular ratios run side by side; both carry the flag, which stage 8 combines.
	logic            par_valid;
	logic [RQ_W-1:0] rpar;
	logic            par_tir;
	logic            perp_valid;
	logic [RQ_W-1:0] rperp;
	logic            perp_tir;

	fdr_ratio u_ratio_par (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (vld_s7),
		.x         (xpar_s7),
		.y         (ypar_s7),
		.tir_in    (tir_s7),
		.out_valid (par_valid),
		.ratio     (rpar),
		.tir_out   (par_tir)
	);

	fdr_ratio u_ratio_perp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (vld_s7),
		.x         (xperp_s7),
		.y         (yperp_s7),
		.tir_in    (tir_s7),
		.out_valid (perp_valid),
		.ratio     (rperp),
		.tir_out   (perp_tir)
	);

	// Stage 8: squared ratios.
	logic            vld_s8;
	logic            tir_s8;
	logic [SQ_W-1:0] sqpar_s8;
	logic [SQ_W-1:0] sqperp_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (ce) begin
			vld_s8 <= par_valid & perp_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			tir_s8    <= par_tir | perp_tir;
			sqpar_s8  <= {{(SQ_W - RQ_W){1'b0}}, rpar} * {{(SQ_W - RQ_W){1'b0}}, rpar};
			sqperp_s8 <= {{(SQ_W - RQ_W){1'b0}}, rperp} * {{(SQ_W - RQ_W){1'b0}}, rperp};
		end
	end

	// Stage 9, the output register: mean of the squares rounded half up and saturated to 1.0; TIR gives 1.0.
	logic [SQ_W:0]     refl_sum;
	logic [SQ_W-16:0]  refl_raw;
	logic [REFL_W-1:0] refl;
	always_comb begin
		refl_sum = {1'b0, sqpar_s8} + {1'b0, sqperp_s8} + (33'd1 << 15);
		refl_raw = refl_sum[SQ_W:16];
		refl     = (refl_raw > {1'b0, ONE_REFL}) ? ONE_REFL : refl_raw[REFL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (ce) begin
			m_tvalid <= vld_s8;
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			m_tdata <= tir_s8 ? ONE_REFL : refl;
			m_tuser <= tir_s8;
		end
	end

endmodule

// ===== bench/fresnel_dielectric_reflectance_checker.sv =====
// Checker for the Fresnel dielectric reflectance unit: watches the cfg, slave and master
// channels, predicts each result and compares it. Depends on fdr_pkg only.
module fresnel_dielectric_reflectance_checker
	import fdr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [COS_W-1:0]      s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [REFL_W-1:0]     m_tdata,
	input  logic                  m_tuser,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_index,
	input  logic [IDX_W-1:0]      cfg_data,
	output int                    errors,
	output int                    pending
);

	typedef struct packed {
		logic [REFL_W-1:0] refl;
		logic              tir;
	} refl_beat_t;

	logic [IDX_W-1:0] n_outer = INDEX_OUTSIDE_RST;
	logic [IDX_W-1:0] n_inner = INDEX_INSIDE_RST;
	refl_beat_t       awaited_refl[$];

	initial errors = 0;
	assign pending = awaited_refl.size();

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 30;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned amp_ratio(longint unsigned x, longint unsigned y);
		longint unsigned d;
		longint unsigned s;
		d = (x > y) ? x - y : y - x;
		s = x + y;
		if (s == 0) return 32768;
		return (d * 32768 + (s >> 1)) / s;
	endfunction

	function automatic refl_beat_t reflectance_of(logic signed [COS_W-1:0] cos_in);
		longint unsigned ni, nt, c, s2, num, nt2, st2, ct, rpar, rperp, r;
		refl_beat_t      b;
		ni = n_outer;
		nt = n_inner;
		if (cos_in > 0) begin
			c = longint'(cos_in);
		end else begin
			ni = n_inner;
			nt = n_outer;
			c = longint'(-longint'(cos_in));
		end
		s2  = (64'd1 << 30) - c * c;
		num = ni * ni * s2;
		nt2 = nt * nt;
		if (num >= (nt2 << 30)) begin
			b.refl = ONE_REFL;
			b.tir  = 1'b1;
			return b;
		end
		st2   = num / nt2;
		ct    = root_floor((64'd1 << 30) - st2);
		rpar  = amp_ratio(nt * c, ni * ct);
		rperp = amp_ratio(ni * c, nt * ct);
		r     = (rpar * rpar + rperp * rperp + 64'd32768) >> 16;
		if (r > 32768) r = 32768;
		b.refl = r[REFL_W-1:0];
		b.tir  = 1'b0;
		return b;
	endfunction

	task automatic report(string what);
		$display("MISMATCH at %0t: %s", $time, what);
		errors++;
	endtask

	always @(posedge clk) begin
		refl_beat_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_INDEX_OUTSIDE) n_outer = cfg_data;
				else if (cfg_index == REG_INDEX_INSIDE) n_inner = cfg_data;
			end
			if (s_tvalid && s_tready)
				awaited_refl.push_back(reflectance_of(s_tdata));
			if (m_tvalid && m_tready) begin
				if (awaited_refl.size() == 0) begin
					report($sformatf("unexpected beat refl=%0d tir=%0d", m_tdata, m_tuser));
				end else begin
					want = awaited_refl.pop_front();
					if (m_tdata !== want.refl)
						report($sformatf("reflectance %0d, expected %0d", m_tdata, want.refl));
					if (m_tuser !== want.tir)
						report($sformatf("total_internal %0d, expected %0d", m_tuser, want.tir));
				end
			end
		end
	end

endmodule

// ===== bench/fresnel_dielectric_reflectance_unit_tb.sv =====
// Top of the Fresnel dielectric reflectance bench: clock, reset, stimulus and verdict.
// Depends on fdr_pkg, the unit and fresnel_dielectric_reflectance_checker.
module fresnel_dielectric_reflectance_unit_tb;
	import fdr_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [COS_W-1:0]      s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [REFL_W-1:0]     m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_index = '0;
	logic [IDX_W-1:0]      cfg_data = '0;
	int                    errors;
	int                    pending;

	// When set, neither side idles; used for the final stretch of the run.
	bit quiet = 0;
	int stall_left = 0;

	always #6 clk = ~clk;

	fresnel_dielectric_reflectance_unit u_dut (.*);

	fresnel_dielectric_reflectance_checker u_chk (.*);

	// The receiver now and then drops m_tready for a burst of random length.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Send one cosine beat. Valid stays high afterwards so back-to-back beats flow
	// without a bubble; an idle burst lowers it first.
	task automatic send_cos(logic [COS_W-1:0] cos_in);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= cos_in;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending and hold off until every outstanding result has come back,
	// so the indices can be changed while the pipeline is empty.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_index(logic [CFG_ADDR_W-1:0] idx, logic [IDX_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Full-range cosines one time in three, with grazing and head-on angles weighted up since
	// that is where total internal reflection and the steep part of the curve live.
	function automatic logic [COS_W-1:0] random_cos();
		case ($urandom_range(0, 5))
			0: return COS_W'($urandom_range(0, 300));
			1: return COS_W'(-$urandom_range(0, 300));
			2: return COS_W'(32767 - $urandom_range(0, 300));
			3: return COS_W'(-32768 + $urandom_range(0, 300));
			default: return COS_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic run_phase(logic [IDX_W-1:0] n_out, logic [IDX_W-1:0] n_in, int count);
		drain();
		write_index(REG_INDEX_OUTSIDE, n_out);
		write_index(REG_INDEX_INSIDE, n_in);
		repeat (count) send_cos(random_cos());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats at the reset indices: zero cosine (treated as leaving, with
		// the indices swapped), the most negative cosine, both extremes, and middle angles.
		send_cos(16'h0000);
		send_cos(16'h0001);
		send_cos(16'hFFFF);
		send_cos(16'h7FFF);
		send_cos(16'h8000);
		send_cos(16'h8001);
		send_cos(16'h4000);
		send_cos(16'hC000);
		send_cos(16'h5555);
		send_cos(16'hAAAA);
		send_cos(16'h0100);
		send_cos(16'hFF00);

		// Beyond-the-list register indices must be ignored by the unit.
		drain();
		write_index(CFG_ADDR_W'(2), 16'h1234);
		write_index(CFG_ADDR_W'(3), 16'hFFFF);
		send_cos(16'hE000);
		send_cos(16'h2000);

		run_phase(16'd4096, 16'd6144, 140);
		run_phase(16'd6144, 16'd4096, 140);
		run_phase(16'd1, 16'd65535, 120);
		run_phase(16'd65535, 16'd1, 120);
		run_phase(16'd65535, 16'd65535, 100);
		run_phase(16'd1, 16'd1, 100);
		repeat (2) begin
			run_phase(IDX_W'($urandom_range(1, 65535)), IDX_W'($urandom_range(1, 65535)), 100);
		end
		run_phase(IDX_W'($urandom_range(3000, 12000)), IDX_W'($urandom_range(3000, 12000)), 100);

		// Final stretch with both sides running flat out.
		drain();
		quiet = 1;
		repeat (100) send_cos(random_cos());
		drain();
		repeat (100) @(posedge clk);

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
